// ----- design/rapd_pkg.sv -----
// rapd_pkg: shared widths, opcodes, status codes, register indexes and reset values
// for the rotate-to-heading PD controller. No dependencies.
`default_nettype none

package rapd_pkg;

  // field widths
  localparam int unsigned OP_W     = 1;
  localparam int unsigned GYRO_W   = 16;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned POWER_W  = 8;
  localparam int unsigned STATUS_W = 2;

  // config register widths
  localparam int unsigned TARGET_W = 10;
  localparam int unsigned PLIM_W   = 7;
  localparam int unsigned KP_W     = 10;
  localparam int unsigned KD_W     = 11;
  localparam int unsigned DLIM_W   = 7;
  localparam int unsigned THR_W    = 8;
  localparam int unsigned BRAKE_W  = 7;

  // stored error width
  localparam int unsigned ERR_STORE_W = 18;

  // apb
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // item opcodes
  localparam logic [OP_W-1:0] OP_START  = 1'b0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_RUNNING = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BRAKING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IDLE    = 2'd3;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_TARGET  = 3'd0;
  localparam logic [2:0] REG_MAXTIME = 3'd1;
  localparam logic [2:0] REG_PLIM    = 3'd2;
  localparam logic [2:0] REG_KP      = 3'd3;
  localparam logic [2:0] REG_KD      = 3'd4;
  localparam logic [2:0] REG_DLIM    = 3'd5;
  localparam logic [2:0] REG_THR     = 3'd6;
  localparam logic [2:0] REG_BRAKE   = 3'd7;

  // register reset values
  localparam logic signed [TARGET_W-1:0] TARGET_RST  = 10'sd90;
  localparam logic [TIME_W-1:0]          MAXTIME_RST = 16'd1000;
  localparam logic [PLIM_W-1:0]          PLIM_RST    = 7'd100;
  localparam logic [KP_W-1:0]            KP_RST      = 10'd74;
  localparam logic [KD_W-1:0]            KD_RST      = 11'd512;
  localparam logic [DLIM_W-1:0]          DLIM_RST    = 7'd30;
  localparam logic [THR_W-1:0]           THR_RST     = 8'd15;
  localparam logic [BRAKE_W-1:0]         BRAKE_RST   = 7'd40;

endpackage

`default_nettype wire

// ----- design/rapd_in_if.sv -----
// rapd_in_if: valid/ready channel carrying one controller input item.
// Depends on rapd_pkg for field widths.
`default_nettype none

interface rapd_in_if
  import rapd_pkg::*;
();

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [GYRO_W-1:0] gyro_reading;
  logic [TIME_W-1:0]        elapsed_time;

  modport source (output valid, op, gyro_reading, elapsed_time, input ready);
  modport sink   (input valid, op, gyro_reading, elapsed_time, output ready);

endinterface

`default_nettype wire

// ----- design/rapd_out_if.sv -----
// rapd_out_if: valid/ready channel carrying one controller result item.
// Depends on rapd_pkg for field widths.
`default_nettype none

interface rapd_out_if
  import rapd_pkg::*;
();

  logic                      valid;
  logic                      ready;
  logic signed [POWER_W-1:0] left_power;
  logic signed [POWER_W-1:0] right_power;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, left_power, right_power, status, input ready);
  modport sink   (input valid, left_power, right_power, status, output ready);

endinterface

`default_nettype wire

// ----- design/rotate_angle_pd_controller.sv -----
// rotate_angle_pd_controller: rotate-to-heading PD controller with a clamped
// derivative term. Depends on rapd_pkg, rapd_in_if and rapd_out_if.
//
// Usage:
//   item   : input channel; op selects start or sample, a sample carries the
//            gyro heading and the elapsed time. One result per item.
//   result : output channel with left/right drive power and a status code.
//   APB    : eight 32-bit registers at byte offsets 0x00..0x1c; write them only
//            while no item is in flight. pready is tied high.
// Flow: an accepted item is latched in the input register; its result is
//   computed from it and loaded into the result register once that register
//   is free, and is offered from then on.
// Throughput: one item per cycle unless stalled; the only loop is the stored
//   error and the armed flag, updated in the same cycle the result is formed.
// Stall: while the result is not taken, the input register still accepts one
//   more item and then holds it; item.ready drops only when both are full.
// Reset: rst (synchronous) empties both registers, disarms the controller,
//   clears the stored error and loads the register defaults.
`default_nettype none

module rotate_angle_pd_controller
  import rapd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  rapd_in_if.sink                item,
  rapd_out_if.source             result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  // configuration registers
  logic signed [TARGET_W-1:0] target_angle;
  logic [TIME_W-1:0]          max_time;
  logic [PLIM_W-1:0]          power_limit;
  logic [KP_W-1:0]            kp_q8;
  logic [KD_W-1:0]            kd_q8;
  logic [DLIM_W-1:0]          deriv_limit;
  logic [THR_W-1:0]           success_threshold;
  logic [BRAKE_W-1:0]         brake_power;

  // controller state
  logic signed [ERR_STORE_W-1:0] previous_error;
  logic                          active;

  // input register
  logic                     in_valid;
  logic [OP_W-1:0]          in_op;
  logic signed [GYRO_W-1:0] in_gyro;
  logic [TIME_W-1:0]        in_time;

  // result register
  logic                      out_valid;
  logic signed [POWER_W-1:0] out_left;
  logic signed [POWER_W-1:0] out_right;
  logic [STATUS_W-1:0]       out_status;

  logic cfg_write;
  logic out_free;
  logic advance;

  // datapath
  logic signed [13:0] target10;
  logic signed [16:0] err;
  logic [16:0]        abs_err;
  logic               reached;
  logic               timed_out;
  logic signed [18:0] diff;
  logic signed [30:0] dprod;
  logic signed [30:0] dlim;
  logic signed [30:0] dterm;
  logic signed [27:0] pprod;
  logic signed [30:0] sum;
  logic signed [30:0] sum_adj;
  logic signed [30:0] pshift;
  logic signed [30:0] plim;
  logic signed [POWER_W-1:0] p_drive;
  logic signed [POWER_W-1:0] brake;

  logic signed [POWER_W-1:0]     left_next;
  logic signed [POWER_W-1:0]     right_next;
  logic [STATUS_W-1:0]           status_next;
  logic                          active_next;
  logic signed [ERR_STORE_W-1:0] previous_error_next;

  // apb write and read
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle      <= TARGET_RST;
      max_time          <= MAXTIME_RST;
      power_limit       <= PLIM_RST;
      kp_q8             <= KP_RST;
      kd_q8             <= KD_RST;
      deriv_limit       <= DLIM_RST;
      success_threshold <= THR_RST;
      brake_power       <= BRAKE_RST;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_TARGET:  target_angle      <= $signed(pwdata[TARGET_W-1:0]);
        REG_MAXTIME: max_time          <= pwdata[TIME_W-1:0];
        REG_PLIM:    power_limit       <= pwdata[PLIM_W-1:0];
        REG_KP:      kp_q8             <= pwdata[KP_W-1:0];
        REG_KD:      kd_q8             <= pwdata[KD_W-1:0];
        REG_DLIM:    deriv_limit       <= pwdata[DLIM_W-1:0];
        REG_THR:     success_threshold <= pwdata[THR_W-1:0];
        REG_BRAKE:   brake_power       <= pwdata[BRAKE_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_TARGET:  prdata = {22'd0, target_angle};
      REG_MAXTIME: prdata = {16'd0, max_time};
      REG_PLIM:    prdata = {25'd0, power_limit};
      REG_KP:      prdata = {22'd0, kp_q8};
      REG_KD:      prdata = {21'd0, kd_q8};
      REG_DLIM:    prdata = {25'd0, deriv_limit};
      REG_THR:     prdata = {24'd0, success_threshold};
      REG_BRAKE:   prdata = {25'd0, brake_power};
      default:     prdata = '0;
    endcase
  end

  // handshake: input register moves on when the result register is free
  assign out_free   = !out_valid || result.ready;
  assign advance    = in_valid && out_free;
  assign item.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_op   <= item.op;
      in_gyro <= item.gyro_reading;
      in_time <= item.elapsed_time;
    end
  end

  // heading error and completion test
  assign target10  = 14'(target_angle) * 14'sd10;
  assign err       = 17'(target10) - 17'(in_gyro);
  assign abs_err   = err[16] ? 17'(-err) : 17'(err);
  assign reached   = abs_err < {9'd0, success_threshold};
  assign timed_out = in_time >= max_time;

  // derivative term with symmetric clamp
  assign diff  = 19'(err) - 19'(previous_error);
  assign dprod = 31'(diff) * $signed({20'd0, kd_q8});
  assign dlim  = $signed({16'd0, deriv_limit, 8'd0});

  always_comb begin
    if (dprod > dlim) begin
      dterm = dlim;
    end else if (dprod < -dlim) begin
      dterm = -dlim;
    end else begin
      dterm = dprod;
    end
  end

  // proportional term, sum, truncation toward zero
  assign pprod   = 28'(err) * $signed({18'd0, kp_q8});
  assign sum     = 31'(pprod) + dterm;
  assign sum_adj = sum + (sum[30] ? 31'sd255 : 31'sd0);
  assign pshift  = sum_adj >>> 8;
  assign plim    = $signed({24'd0, power_limit});

  // power clamp
  always_comb begin
    if (pshift > plim) begin
      p_drive = POWER_W'(plim);
    end else if (pshift < -plim) begin
      p_drive = POWER_W'(-plim);
    end else begin
      p_drive = POWER_W'(pshift);
    end
  end

  assign brake = $signed({1'b0, brake_power});

  // result and state update selection
  always_comb begin
    left_next           = '0;
    right_next          = '0;
    status_next         = ST_RUNNING;
    active_next         = active;
    previous_error_next = previous_error;
    if (in_op == OP_START) begin
      active_next         = 1'b1;
      previous_error_next = '0;
    end else if (!active) begin
      status_next = ST_IDLE;
    end else if (timed_out) begin
      status_next = ST_TIMEOUT;
      active_next = 1'b0;
    end else if (reached) begin
      status_next = ST_BRAKING;
      active_next = 1'b0;
      if (target10 > 14'sd0) begin
        left_next  = brake;
        right_next = -brake;
      end else begin
        left_next  = -brake;
        right_next = brake;
      end
    end else begin
      left_next           = -p_drive;
      right_next          = p_drive;
      previous_error_next = ERR_STORE_W'(err);
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      previous_error <= '0;
    end else if (advance) begin
      active         <= active_next;
      previous_error <= previous_error_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_left   <= left_next;
      out_right  <= right_next;
      out_status <= status_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.left_power  = out_left;
  assign result.right_power = out_right;
  assign result.status      = out_status;

endmodule

`default_nettype wire

// ----- design/rapd_checker.sv -----
// rapd_checker: port-level assertions for rotate_angle_pd_controller, and the
// bind that attaches them. Depends on rapd_pkg.
`default_nettype none

module rapd_checker
  import rapd_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic signed [POWER_W-1:0] left_power,
  input wire logic signed [POWER_W-1:0] right_power,
  input wire logic [STATUS_W-1:0]       status
);

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // a stalled result stays offered
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // rotation drive is always an opposing pair
  a_opposing: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_power + right_power) == 8'd0)
    else $error("left and right power not opposite");

  // timeout and idle results carry no drive
  a_zero_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_TIMEOUT || status == ST_IDLE)
      |-> left_power == 8'sd0 && right_power == 8'sd0)
    else $error("drive present on timeout or idle result");

endmodule

bind rotate_angle_pd_controller rapd_checker u_rapd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .left_power  (result.left_power),
  .right_power (result.right_power),
  .status      (result.status)
);

`default_nettype wire
